>>> hdl/assert_macros.svh
// Assertion macros shared by the checksum RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define LUHN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LUHN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/luhn_pkg.sv
// Types and constants shared by the Luhn mod-N checksum modules.
package luhn_pkg;

  localparam int unsigned MOD_W = 16;
  localparam int unsigned NUM_W = 64;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(10);
  localparam logic [MOD_W-1:0] MIN_BASE  = MOD_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FIN
  } luhn_state_e;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [MOD_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> hdl/luhn_mod_n_checksum.sv
// Top level of the Luhn mod-N checksum: modulus register, sequencer, divider, result register.
//
//   channel   dir  handshake              payload
//   in        in   in_valid_i/in_ready_o  number_i[63:0]
//   out       out  out_valid_o/out_ready_i check_value_o[15:0], is_valid_o
//   cfg       in   cfg_we_i               cfg_wdata_i[15:0] (modulus)
//
// Each word runs one division per base-N digit of the number (0 to 64 digits), each on the
// shared divider in 64 steps, one quotient bit per cycle. The next word is taken only once
// the last one has passed its result to the result register.
// Reset (rst_ni low, asynchronous) sets the modulus to ten and empties the result register.
// A modulus below two works as two. in_ready_o is high only while no word is in work.
// A result held by a stalled output keeps the next word from finishing, not from entering.
`include "assert_macros.svh"

module luhn_mod_n_checksum (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [luhn_pkg::NUM_W-1:0] number_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [luhn_pkg::MOD_W-1:0] check_value_o,
  output logic                       is_valid_o,
  input  logic                       cfg_we_i,
  input  logic [luhn_pkg::MOD_W-1:0] cfg_wdata_i
);
  import luhn_pkg::*;

  logic [MOD_W-1:0] modulus_q;
  logic [MOD_W-1:0] base;

  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  div_rsp_t         div_rsp;

  logic             res_valid;
  logic             res_ready;
  logic [MOD_W-1:0] res_value;

  logic             out_valid_q, out_valid_d;
  logic [MOD_W-1:0] check_q, check_d;
  logic             flag_q, flag_d;

  // Modulus register; to be written only between words, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i;
    end
  end

  // Clamp the base so the digit split always ends.
  assign base = (modulus_q < MIN_BASE) ? MIN_BASE : modulus_q;

  luhn_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_i         (base),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .number_i       (number_i),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_rsp_i      (div_rsp),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_value_o    (res_value)
  );

  luhn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .base_i     (base),
    .rsp_o      (div_rsp)
  );

  // Result register: take a new word when empty or being drained this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    check_d     = check_q;
    flag_d      = flag_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      check_d     = res_value;
      flag_d      = (res_value == '0);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    check_q <= check_d;
    flag_q  <= flag_d;
  end

  assign out_valid_o   = out_valid_q;
  assign check_value_o = check_q;
  assign is_valid_o    = flag_q;

  `LUHN_ASSERT_IMPL(a_top_flag_match, out_valid_o, is_valid_o == (check_value_o == '0), "flag mismatch")
  `LUHN_ASSERT_IMPL(a_top_busy_no_in, res_valid, !in_ready_o, "input open while a result is pending")

endmodule

>>> hdl/luhn_div.sv
// Shared restoring divider: 64-bit dividend by a 16-bit base, one quotient bit a cycle.
`include "assert_macros.svh"

module luhn_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [luhn_pkg::NUM_W-1:0] dividend_i,
  input  logic [luhn_pkg::MOD_W-1:0] base_i,
  output luhn_pkg::div_rsp_t        rsp_o
);
  import luhn_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [MOD_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [MOD_W:0]   trial;
  logic             fits;

  // Bring down the next dividend bit and try the subtract.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, base_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? MOD_W'(trial - {1'b0, base_i}) : trial[MOD_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

  `LUHN_ASSERT_IMPL(a_div_rem_range, rsp_o.done, rsp_o.rem < base_i, "divider remainder not below base")
  `LUHN_ASSERT_IMPL(a_div_no_restart, start_i, !busy_q, "divider started while busy")

endmodule

>>> hdl/luhn_ctrl.sv
// Digit sequencer: drives the divider, weights each digit and folds it into the sum.
`include "assert_macros.svh"

module luhn_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [luhn_pkg::MOD_W-1:0] base_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [luhn_pkg::NUM_W-1:0] number_i,
  output logic                       div_start_o,
  output logic [luhn_pkg::NUM_W-1:0] div_dividend_o,
  input  luhn_pkg::div_rsp_t         div_rsp_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output logic [luhn_pkg::MOD_W-1:0] res_value_o
);
  import luhn_pkg::*;

  luhn_state_e      state_q, state_d;
  logic [NUM_W-1:0] value_q, value_d;
  logic [MOD_W-1:0] acc_q, acc_d;
  logic             odd_q, odd_d;

  logic [MOD_W:0]   dbl;
  logic [MOD_W-1:0] digit;
  logic [MOD_W:0]   sum;

  // Weight the digit: double odd positions, fold back when it reaches the base.
  always_comb begin
    dbl   = {div_rsp_i.rem, 1'b0};
    digit = div_rsp_i.rem;
    if (odd_q) begin
      digit = (dbl >= {1'b0, base_i}) ? MOD_W'(dbl - {1'b0, base_i} + (MOD_W+1)'(1))
                                      : dbl[MOD_W-1:0];
    end
    sum = {1'b0, acc_q} + {1'b0, digit};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK: state_d = (value_q == '0) ? ST_FIN : ST_DIV;
      ST_DIV:   if (div_rsp_i.done) state_d = ST_CHECK;
      ST_FIN:   if (res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    div_start_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o  = 1'b1;
      ST_CHECK: div_start_o = (value_q != '0);
      ST_DIV:   ;
      ST_FIN:   res_valid_o = 1'b1;
      default:  ;
    endcase
  end

  // Datapath.
  always_comb begin
    value_d = value_q;
    acc_d   = acc_q;
    odd_d   = odd_q;
    if (state_q == ST_IDLE && in_valid_i) begin
      value_d = number_i;
      acc_d   = '0;
      odd_d   = 1'b0;
    end else if (state_q == ST_DIV && div_rsp_i.done) begin
      value_d = div_rsp_i.quo;
      acc_d   = (sum >= {1'b0, base_i}) ? MOD_W'(sum - {1'b0, base_i}) : sum[MOD_W-1:0];
      odd_d   = !odd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    acc_q   <= acc_d;
    odd_q   <= odd_d;
  end

  assign div_dividend_o = value_q;
  assign res_value_o    = acc_q;

  `LUHN_ASSERT_IMPL(a_ctrl_acc_range, state_q != ST_IDLE, acc_q < base_i, "running sum not reduced")

endmodule

>>> test/luhn_mod_n_checksum_tb.sv
// Testbench for the Luhn mod-N checksum: random and directed words checked against a predictor.
`timescale 1ns / 100ps

module luhn_mod_n_checksum_tb;
  import luhn_pkg::*;

  // Give up after this many cycles in which neither side moves a word.
  localparam int unsigned STALL_LIMIT = 60000;
  // Receiver hold-off; long enough for the block to fill and drop in_ready_o.
  localparam int unsigned HOLD_CYCLES = 13000;
  // Allowance for the slowest word, one of 64 digits.
  localparam int unsigned WORD_CYCLES = 4300;

  typedef struct packed {
    logic [MOD_W-1:0] check_value;
    logic             is_valid;
  } checksum_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [NUM_W-1:0] number = '0;
  logic             out_ready = 1'b0;
  logic             cfg_we = 1'b0;
  logic [MOD_W-1:0] cfg_wdata = '0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [MOD_W-1:0] check_value_o;
  logic             is_valid_o;

  // Testbench copy of the modulus register.
  logic [MOD_W-1:0] cur_mod = MOD_RESET;

  logic [NUM_W-1:0] number_q[$];     // words waiting to be offered
  checksum_t        checksum_q[$];   // predicted checksums, oldest first

  int unsigned idle_pct = 30;
  int unsigned hold_req = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned errors = 0;
  logic        word_taken = 1'b0;
  logic        result_taken = 1'b0;

  luhn_mod_n_checksum u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .number_i      (number),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .check_value_o (check_value_o),
    .is_valid_o    (is_valid_o),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Weighted digit sum in base mod, reduced modulo mod; a modulus below two acts as two.
  function automatic logic [MOD_W-1:0] luhn_residue(logic [NUM_W-1:0] num,
                                                    logic [MOD_W-1:0] mod);
    logic [NUM_W-1:0] base;
    logic [NUM_W-1:0] rest;
    logic [NUM_W-1:0] digit;
    logic [NUM_W-1:0] acc;
    logic             doubled;
    base    = (mod < MIN_BASE) ? NUM_W'(MIN_BASE) : NUM_W'(mod);
    rest    = num;
    acc     = '0;
    doubled = 1'b0;
    while (rest != 0) begin
      digit = rest % base;
      rest  = rest / base;
      if (doubled) begin
        digit = digit * 2;
        // Fold a two-digit product back into one digit.
        if (digit >= base) begin
          digit = digit - (base - 1);
        end
      end
      doubled = !doubled;
      acc     = acc + digit;
    end
    return MOD_W'(acc % base);
  endfunction

  // Pick a random word; half carry a check digit that makes the sum come out to zero.
  function automatic logic [NUM_W-1:0] pick_number(logic [MOD_W-1:0] mod);
    logic [NUM_W-1:0] raw;
    logic [NUM_W-1:0] base;
    logic [NUM_W-1:0] num;
    logic [MOD_W-1:0] rem;
    raw  = {$urandom, $urandom};
    base = (mod < MIN_BASE) ? NUM_W'(MIN_BASE) : NUM_W'(mod);
    case ($urandom_range(5))
      0: begin
        num = raw >> $urandom_range(NUM_W - 1);
      end
      1: begin
        num = raw;
      end
      2: begin
        num = raw | (NUM_W'(1) << (NUM_W - 1));
      end
      default: begin
        // Clear the lowest digit, then fill it with the digit that cancels the residue.
        num = ((raw >> 1) / base) * base;
        rem = luhn_residue(num, mod);
        num = num + (base - NUM_W'(rem)) % base;
      end
    endcase
    return num;
  endfunction

  task automatic push_random(int unsigned n);
    repeat (n) number_q.push_back(pick_number(cur_mod));
  endtask

  // Block until every queued word has gone in and every checksum has come back.
  task automatic wait_drained();
    do @(posedge clk); while (number_q.size() != 0 || in_valid || checksum_q.size() != 0);
  endtask

  // Write the modulus while the block is idle.
  task automatic write_modulus(logic [MOD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_mod = value;
    @(posedge clk);
  endtask

  // Sender: hold a word until taken, then offer the next one or idle at random.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !word_taken)) begin
      if (number_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        number   <= number_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_done < hold_req) begin
      hold_done = hold_done + 1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: predict on every accepted word, check every accepted result, watch for hangs.
  always @(posedge clk) begin
    checksum_t want;
    word_taken   = 1'b0;
    result_taken = 1'b0;
    if (rst_n) begin
      word_taken   = in_valid && in_ready_o;
      result_taken = out_valid_o && out_ready;
      if (word_taken) begin
        want.check_value = luhn_residue(number, cur_mod);
        want.is_valid    = (want.check_value == '0);
        checksum_q.push_back(want);
      end
      if (result_taken) begin
        if (checksum_q.size() == 0) begin
          $error("result with no word outstanding: check_value %0d is_valid %0b",
                 check_value_o, is_valid_o);
          errors = errors + 1;
        end else begin
          want = checksum_q.pop_front();
          if (check_value_o !== want.check_value) begin
            $error("check_value: expected %0d, got %0d", want.check_value, check_value_o);
            errors = errors + 1;
          end
          if (is_valid_o !== want.is_valid) begin
            $error("is_valid: expected %0b, got %0b", want.is_valid, is_valid_o);
            errors = errors + 1;
          end
        end
      end
      if (word_taken || result_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset modulus of ten: zero, single digits, classic card numbers, bit patterns.
    number_q.push_back(64'd0);
    number_q.push_back(64'd1);
    number_q.push_back(64'd9);
    number_q.push_back(64'd18);
    number_q.push_back(64'd59);
    number_q.push_back(64'd90);
    number_q.push_back(64'd79927398713);
    number_q.push_back(64'd79927398710);
    number_q.push_back('1);
    number_q.push_back(64'h8000_0000_0000_0000);
    number_q.push_back(64'h5555_5555_5555_5555);
    number_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    push_random(6);
    wait_drained();

    // Modulus zero acts as two: the slowest case, 64 digits.
    write_modulus(16'd0);
    number_q.push_back(64'd0);
    number_q.push_back(64'd1);
    number_q.push_back(64'd2);
    number_q.push_back(64'd3);
    number_q.push_back('1);
    push_random(8);
    wait_drained();

    // Modulus one acts as two as well.
    write_modulus(16'd1);
    number_q.push_back('1);
    number_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    number_q.push_back(64'd6);
    wait_drained();

    // Widest modulus.
    write_modulus(16'hFFFF);
    number_q.push_back(64'd0);
    number_q.push_back(64'd65534);
    number_q.push_back(64'd65535);
    number_q.push_back(64'd65536);
    number_q.push_back('1);
    push_random(15);
    wait_drained();

    // Back to ten, with a long stretch where neither side idles.
    write_modulus(16'd10);
    @(posedge clk);
    idle_pct = 0;
    push_random(30);
    wait_drained();
    idle_pct = 30;

    write_modulus(16'd2);
    push_random(8);
    wait_drained();

    write_modulus(16'd36);
    push_random(20);
    wait_drained();

    // Random modulus; stall the receiver while the sender keeps offering words.
    write_modulus(MOD_W'($urandom_range(65534, 3)));
    @(posedge clk);
    idle_pct = 0;
    hold_req = hold_req + 1;
    push_random(20);
    wait_drained();
    idle_pct = 30;

    write_modulus(16'd16);
    push_random(20);
    wait_drained();

    // Let any stray result show up before the verdict.
    repeat (WORD_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/luhn_pkg.sv
hdl/luhn_div.sv
hdl/luhn_ctrl.sv
hdl/luhn_mod_n_checksum.sv
test/luhn_mod_n_checksum_tb.sv
